// ===== design/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

   // event codes
   localparam logic [3:0] FN_TICK      = 4'd0;
   localparam logic [3:0] FN_CREATE    = 4'd1;
   localparam logic [3:0] FN_DELETE    = 4'd2;
   localparam logic [3:0] FN_ACTIVATE  = 4'd3;
   localparam logic [3:0] FN_TERMINATE = 4'd4;
   localparam logic [3:0] FN_SLEEP     = 4'd5;
   localparam logic [3:0] FN_IO_WAIT   = 4'd6;
   localparam logic [3:0] FN_IO_DONE   = 4'd7;
   localparam logic [3:0] FN_QUERY     = 4'd8;

   // status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_BAD_ID    = 3'd1;
   localparam logic [2:0] STS_BAD_STATE = 3'd2;
   localparam logic [2:0] STS_BAD_PARAM = 3'd3;
   localparam logic [2:0] STS_FULL      = 3'd4;

   // thread states
   localparam logic [2:0] TS_DEAD    = 3'd0;
   localparam logic [2:0] TS_RUNNING = 3'd1;
   localparam logic [2:0] TS_READY   = 3'd2;
   localparam logic [2:0] TS_WAITING = 3'd3;
   localparam logic [2:0] TS_EMPTY   = 3'd4;

   // priorities
   localparam logic [1:0] PR_IDLE   = 2'd0;
   localparam logic [1:0] PR_LOW    = 2'd1;
   localparam logic [1:0] PR_NORMAL = 2'd2;
   localparam logic [1:0] PR_HIGH   = 2'd3;

   localparam int IDLE_ID = 1;

   typedef struct packed {
      logic [3:0]  func;
      logic [4:0]  target_thread;
      logic [1:0]  new_priority;
      logic [15:0] sleep_ticks;
      logic        sleep_forever;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] running_now;
      logic       switched;
      logic [4:0] created_id;
      logic [2:0] queried_state;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_POP,
      S_POP_WAIT,
      S_RUN_WR,
      S_SCHED,
      S_SCHED_EV,
      S_RM_RD,
      S_RM_CHK,
      S_TICK_RD,
      S_TICK_EV,
      S_TICK_NEXT,
      S_DONE
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== design/priority_thread_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Events are handled one at a time: a tick scans the slots serially through the one-read
// one-write slot table, and a terminate walks its ready queue entry by entry. The next event
// is taken the cycle after the result; rsp_valid strobes once per transfer and the receiver
// cannot stall. Synchronous reset: no clearing pass, valid bits give the reset table
// contents at once.
module priority_thread_scheduler_core
   import pts_pkg::*;
#(
   parameter int MAX_THREADS = 32,
   parameter int TICK_BITS   = 16
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int ID_W  = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam int QA_W  = ID_W + 2;
   localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

   typedef struct packed {
      logic [2:0]           st;
      logic [1:0]           pr;
      logic [TICK_BITS-1:0] sl;
   } slot_type;

   // wraps a queue position around the table size
   function automatic logic [ID_W-1:0] wrap_add(input logic [ID_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(MAX_THREADS)) s = s - (CNT_W+1)'(MAX_THREADS);
      return ID_W'(s);
   endfunction

   // ---------------------------------------------------------------------
   // Memories: slot table (state, priority, sleep count) and ready queues.
   // Queue memory address is {priority, position}.
   // ---------------------------------------------------------------------
   slot_type           slot_mem [MAX_THREADS];
   logic [ID_W-1:0]    queue_mem [1 << QA_W];

   logic               slot_wr_en;
   logic [ID_W-1:0]    slot_wr_addr;
   slot_type           slot_wr_data;
   logic [ID_W-1:0]    slot_rd_addr;
   slot_type           slot_q_ff;
   logic               rd_vld_ff;
   logic [ID_W-1:0]    rd_addr_ff;
   logic [MAX_THREADS-1:0] vld_ff;
   slot_type           ent;

   logic               q_wr_en;
   logic [QA_W-1:0]    q_wr_addr;
   logic [ID_W-1:0]    q_wr_data;
   logic [QA_W-1:0]    q_rd_addr;
   logic [ID_W-1:0]    q_rdata_ff;

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      slot_q_ff  <= slot_mem[slot_rd_addr];
      rd_vld_ff  <= vld_ff[slot_rd_addr];
      rd_addr_ff <= slot_rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (slot_wr_en) begin
         vld_ff[slot_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[q_wr_addr] <= q_wr_data;
      end
      q_rdata_ff <= queue_mem[q_rd_addr];
   end

   // never-written slots read as their reset contents
   always_comb begin
      if (rd_vld_ff) begin
         ent = slot_q_ff;
      end else if (rd_addr_ff == '0) begin
         ent = '{st: TS_RUNNING, pr: PR_NORMAL, sl: '0};
      end else if (rd_addr_ff == ID_W'(IDLE_ID)) begin
         ent = '{st: TS_READY, pr: PR_IDLE, sl: '0};
      end else begin
         ent = '{st: TS_EMPTY, pr: PR_IDLE, sl: '0};
      end
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   fsm_state_type      state_ff, state_in;
   req_type            req_ff, req_in;
   logic [2:0]         status_ff, status_in;
   logic [4:0]         created_ff, created_in;
   logic [2:0]         qstate_ff, qstate_in;
   logic [ID_W-1:0]    before_ff, before_in;
   logic [ID_W-1:0]    cur_ff, cur_in;
   logic [ID_W-1:0]    op_id_ff, op_id_in;
   logic [CNT_W-1:0]   next_id_ff, next_id_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   rm_i_ff, rm_i_in;
   logic [CNT_W-1:0]   rm_w_ff, rm_w_in;
   logic [1:0]         rm_p_ff, rm_p_in;
   logic [ID_W-1:0]    head_ff [1:3];
   logic [ID_W-1:0]    head_in [1:3];
   logic [ID_W-1:0]    tail_ff [1:3];
   logic [ID_W-1:0]    tail_in [1:3];
   logic [CNT_W-1:0]   cnt_ff  [1:3];
   logic [CNT_W-1:0]   cnt_in  [1:3];

   // queue pointer requests
   logic               enq_en;
   logic [1:0]         enq_p;
   logic [ID_W-1:0]    enq_t;
   logic               enq_ok;
   logic               pop_en;
   logic [1:0]         pop_p;
   logic               rm_fin;
   logic               rm_wr;

   // ---------------------------------------------------------------------
   // Decode helpers
   // ---------------------------------------------------------------------
   logic               tgt_ok;
   logic [ID_W-1:0]    tgt_id;
   logic               any_rdy;
   logic [1:0]         best_p;
   logic               gone;
   logic               sch_ret;
   logic               sch_to_idle;
   logic               sch_preempt;
   logic [1:0]         sch_pop_p;
   logic               is_tick;
   logic [TICK_BITS-1:0] sleep_sat;
   logic [ID_W-1:0]    rm_pos;
   logic               ev_ok;

   assign tgt_ok  = 32'(req_item.target_thread) < MAX_THREADS;
   assign tgt_id  = ID_W'(req_item.target_thread);
   assign any_rdy = (cnt_ff[1] != '0) || (cnt_ff[2] != '0) || (cnt_ff[3] != '0);
   assign best_p  = (cnt_ff[3] != '0) ? PR_HIGH : ((cnt_ff[2] != '0) ? PR_NORMAL : PR_LOW);
   assign gone    = (ent.st == TS_WAITING) || (ent.st == TS_DEAD);
   assign is_tick = req_ff.func == FN_TICK;
   assign rm_pos  = wrap_add(head_ff[rm_p_ff], rm_i_ff);
   assign sleep_sat = (33'(req_ff.sleep_ticks) > TICK_MAX) ? TICK_BITS'(TICK_MAX)
                                                            : TICK_BITS'(req_ff.sleep_ticks);

   // scheduler decision on the running thread's entry
   always_comb begin
      sch_ret     = 1'b0;
      sch_to_idle = 1'b0;
      sch_preempt = 1'b0;
      sch_pop_p   = best_p;
      if (ent.pr == PR_IDLE && !any_rdy) begin
         sch_ret = 1'b1;
      end else if (gone && !any_rdy) begin
         sch_to_idle = 1'b1;
      end else if (gone || ent.pr == PR_IDLE) begin
         sch_pop_p = best_p;
      end else if (ent.pr != PR_HIGH && cnt_ff[3] != '0) begin
         sch_preempt = 1'b1;
         sch_pop_p   = PR_HIGH;
      end else if (ent.pr == PR_LOW && cnt_ff[2] != '0) begin
         sch_preempt = 1'b1;
         sch_pop_p   = PR_NORMAL;
      end else begin
         sch_ret = 1'b1;
      end
   end

   // event checks on the fetched entry
   always_comb begin
      ev_ok = 1'b0;
      case (req_ff.func) inside
         FN_DELETE, FN_ACTIVATE: ev_ok = ent.st == TS_DEAD;
         FN_TERMINATE: ev_ok = ent.st != TS_EMPTY && ent.st != TS_DEAD
                               && op_id_ff != ID_W'(IDLE_ID);
         FN_IO_DONE:   ev_ok = ent.st == TS_WAITING && ent.sl == '0;
         default:      ev_ok = 1'b1;
      endcase
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_item.func) inside
                  FN_TICK: state_in = S_TICK_RD;
                  FN_DELETE, FN_ACTIVATE, FN_TERMINATE, FN_IO_DONE, FN_QUERY:
                     state_in = tgt_ok ? S_EVAL : S_DONE;
                  FN_SLEEP:
                     state_in = (req_item.sleep_forever || cur_ff == ID_W'(IDLE_ID))
                                ? S_DONE : S_EVAL;
                  FN_IO_WAIT: state_in = (cur_ff == ID_W'(IDLE_ID)) ? S_DONE : S_EVAL;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_EVAL: begin
            if (ent.st == TS_EMPTY || !ev_ok) begin
               state_in = S_DONE;
            end else begin
               unique case (req_ff.func) inside
                  FN_ACTIVATE, FN_IO_DONE, FN_IO_WAIT: state_in = S_SCHED;
                  FN_TERMINATE: state_in = (ent.pr != PR_IDLE) ? S_RM_RD : S_SCHED;
                  FN_SLEEP: state_in = (req_ff.sleep_ticks == '0) ? S_POP : S_SCHED;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_POP:      state_in = S_POP_WAIT;
         S_POP_WAIT: state_in = S_RUN_WR;
         S_RUN_WR:   state_in = is_tick ? S_TICK_NEXT : S_DONE;
         S_SCHED:    state_in = S_SCHED_EV;
         S_SCHED_EV: begin
            if (sch_ret) begin
               state_in = is_tick ? S_TICK_NEXT : S_DONE;
            end else if (sch_to_idle) begin
               state_in = S_RUN_WR;
            end else begin
               state_in = S_POP_WAIT;
            end
         end
         S_RM_RD:  state_in = (rm_i_ff == cnt_ff[rm_p_ff]) ? S_SCHED : S_RM_CHK;
         S_RM_CHK: state_in = S_RM_RD;
         S_TICK_RD: state_in = (idx_ff == CNT_W'(MAX_THREADS)) ? S_DONE : S_TICK_EV;
         S_TICK_EV: state_in = (ent.sl == TICK_BITS'(1)) ? S_SCHED : S_TICK_NEXT;
         S_TICK_NEXT: state_in = S_TICK_RD;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and memory controls
   // ---------------------------------------------------------------------
   always_comb begin
      req_in     = req_ff;
      status_in  = status_ff;
      created_in = created_ff;
      qstate_in  = qstate_ff;
      before_in  = before_ff;
      cur_in     = cur_ff;
      op_id_in   = op_id_ff;
      next_id_in = next_id_ff;
      idx_in     = idx_ff;
      rm_i_in    = rm_i_ff;
      rm_w_in    = rm_w_ff;
      rm_p_in    = rm_p_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = op_id_ff;
      slot_wr_data = ent;
      slot_rd_addr = op_id_ff;
      enq_en = 1'b0;
      enq_p  = ent.pr;
      enq_t  = op_id_ff;
      pop_en = 1'b0;
      pop_p  = best_p;
      rm_fin = 1'b0;
      rm_wr  = 1'b0;
      q_rd_addr = {best_p, head_ff[best_p]};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_item;
               status_in  = STS_OK;
               created_in = '0;
               qstate_in  = '0;
               before_in  = cur_ff;
               idx_in     = '0;
               op_id_in   = tgt_id;
               if (req_item.func == FN_SLEEP || req_item.func == FN_IO_WAIT) begin
                  op_id_in = cur_ff;
               end
               slot_rd_addr = op_id_in;
               case (req_item.func) inside
                  FN_TICK: ;
                  FN_CREATE: begin
                     if (req_item.new_priority == PR_IDLE) begin
                        status_in = STS_BAD_PARAM;
                     end else if (next_id_ff >= CNT_W'(MAX_THREADS)) begin
                        status_in = STS_FULL;
                     end else begin
                        slot_wr_en   = 1'b1;
                        slot_wr_addr = ID_W'(next_id_ff);
                        slot_wr_data = '{st: TS_DEAD, pr: req_item.new_priority, sl: '0};
                        created_in   = 5'(next_id_ff);
                        next_id_in   = next_id_ff + CNT_W'(1);
                     end
                  end
                  FN_DELETE, FN_ACTIVATE, FN_TERMINATE, FN_IO_DONE: begin
                     if (!tgt_ok) status_in = STS_BAD_ID;
                  end
                  FN_QUERY: begin
                     if (!tgt_ok) begin
                        status_in = STS_BAD_ID;
                        qstate_in = TS_EMPTY;
                     end
                  end
                  FN_SLEEP: begin
                     if (req_item.sleep_forever) status_in = STS_BAD_PARAM;
                     else if (cur_ff == ID_W'(IDLE_ID)) status_in = STS_BAD_STATE;
                  end
                  FN_IO_WAIT: begin
                     if (cur_ff == ID_W'(IDLE_ID)) status_in = STS_BAD_STATE;
                  end
                  default: status_in = STS_BAD_PARAM;
               endcase
            end
         end
         S_EVAL: begin
            if (ent.st == TS_EMPTY && req_ff.func != FN_SLEEP
                && req_ff.func != FN_IO_WAIT) begin
               status_in = STS_BAD_ID;
               if (req_ff.func == FN_QUERY) qstate_in = TS_EMPTY;
            end else if (!ev_ok) begin
               status_in = STS_BAD_STATE;
            end else begin
               case (req_ff.func) inside
                  FN_DELETE: begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '{st: TS_EMPTY, pr: ent.pr, sl: '0};
                  end
                  FN_ACTIVATE, FN_IO_DONE: begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '{st: TS_READY, pr: ent.pr, sl: ent.sl};
                     enq_en       = 1'b1;
                  end
                  FN_TERMINATE: begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '{st: TS_DEAD, pr: ent.pr, sl: '0};
                     rm_p_in = ent.pr;
                     rm_i_in = '0;
                     rm_w_in = '0;
                  end
                  FN_SLEEP: begin
                     slot_wr_en = 1'b1;
                     if (req_ff.sleep_ticks == '0) begin
                        slot_wr_data = '{st: TS_READY, pr: ent.pr, sl: ent.sl};
                        enq_en       = 1'b1;
                     end else begin
                        slot_wr_data = '{st: TS_WAITING, pr: ent.pr, sl: sleep_sat};
                     end
                  end
                  FN_IO_WAIT: begin
                     slot_wr_en   = 1'b1;
                     slot_wr_data = '{st: TS_WAITING, pr: ent.pr, sl: '0};
                  end
                  FN_QUERY: qstate_in = ent.st;
                  default: ;
               endcase
            end
         end
         S_POP: begin
            pop_en    = 1'b1;
            pop_p     = best_p;
            q_rd_addr = {best_p, head_ff[best_p]};
         end
         S_POP_WAIT: begin
            cur_in       = q_rdata_ff;
            slot_rd_addr = q_rdata_ff;
         end
         S_RUN_WR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = cur_ff;
            slot_wr_data = '{st: TS_RUNNING, pr: ent.pr, sl: ent.sl};
         end
         S_SCHED: begin
            slot_rd_addr = cur_ff;
         end
         S_SCHED_EV: begin
            if (sch_to_idle) begin
               cur_in       = ID_W'(IDLE_ID);
               slot_rd_addr = ID_W'(IDLE_ID);
            end else if (!sch_ret) begin
               pop_en    = 1'b1;
               pop_p     = sch_pop_p;
               q_rd_addr = {sch_pop_p, head_ff[sch_pop_p]};
               if (gone) begin
                  slot_wr_en = 1'b0;
               end else begin
                  // preempted or idle runner goes back to ready
                  slot_wr_en   = 1'b1;
                  slot_wr_addr = cur_ff;
                  slot_wr_data = '{st: TS_READY, pr: ent.pr, sl: ent.sl};
                  enq_en       = sch_preempt;
                  enq_p        = ent.pr;
                  enq_t        = cur_ff;
               end
            end
         end
         S_RM_RD: begin
            q_rd_addr = {rm_p_ff, rm_pos};
            if (rm_i_ff == cnt_ff[rm_p_ff]) rm_fin = 1'b1;
         end
         S_RM_CHK: begin
            if (q_rdata_ff != op_id_ff) begin
               rm_wr   = 1'b1;
               rm_w_in = rm_w_ff + CNT_W'(1);
            end
            rm_i_in = rm_i_ff + CNT_W'(1);
         end
         S_TICK_RD: begin
            slot_rd_addr = ID_W'(idx_ff);
         end
         S_TICK_EV: begin
            slot_wr_addr = ID_W'(idx_ff);
            if (ent.sl != '0) begin
               slot_wr_en = 1'b1;
               slot_wr_data = '{st: (ent.sl == TICK_BITS'(1)) ? TS_READY : ent.st,
                                pr: ent.pr, sl: ent.sl - TICK_BITS'(1)};
               if (ent.sl == TICK_BITS'(1)) begin
                  enq_en = 1'b1;
                  enq_t  = ID_W'(idx_ff);
               end
            end
         end
         S_TICK_NEXT: begin
            idx_in = idx_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   // queue memory write port: enqueue or compaction during removal
   always_comb begin
      enq_ok = 1'b0;
      for (int k = 1; k <= 3; k++) begin
         if (enq_p == 2'(k) && cnt_ff[k] < CNT_W'(MAX_THREADS)) enq_ok = 1'b1;
      end
   end

   always_comb begin
      if (rm_wr) begin
         q_wr_en   = 1'b1;
         q_wr_addr = {rm_p_ff, wrap_add(head_ff[rm_p_ff], rm_w_ff)};
         q_wr_data = q_rdata_ff;
      end else begin
         q_wr_en   = enq_en && enq_ok;
         q_wr_addr = {enq_p, tail_ff[(enq_p == PR_IDLE) ? PR_LOW : enq_p]};
         q_wr_data = enq_t;
      end
   end

   // queue pointers
   always_comb begin
      for (int k = 1; k <= 3; k++) begin
         head_in[k] = head_ff[k];
         tail_in[k] = tail_ff[k];
         cnt_in[k]  = cnt_ff[k];
         if (enq_en && enq_ok && enq_p == 2'(k)) begin
            tail_in[k] = wrap_add(tail_ff[k], CNT_W'(1));
            cnt_in[k]  = cnt_ff[k] + CNT_W'(1);
         end
         if (pop_en && pop_p == 2'(k)) begin
            head_in[k] = wrap_add(head_ff[k], CNT_W'(1));
            cnt_in[k]  = cnt_ff[k] - CNT_W'(1);
         end
         if (rm_fin && rm_p_ff == 2'(k)) begin
            cnt_in[k]  = rm_w_ff;
            tail_in[k] = wrap_add(head_ff[k], rm_w_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cur_ff     <= '0;
         next_id_ff <= CNT_W'(2);
         for (int k = 1; k <= 3; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cur_ff     <= cur_in;
         next_id_ff <= next_id_in;
         for (int k = 1; k <= 3; k++) begin
            head_ff[k] <= head_in[k];
            tail_ff[k] <= tail_in[k];
            cnt_ff[k]  <= cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      created_ff <= created_in;
      qstate_ff  <= qstate_in;
      before_ff  <= before_in;
      op_id_ff   <= op_id_in;
      idx_ff     <= idx_in;
      rm_i_ff    <= rm_i_in;
      rm_w_ff    <= rm_w_in;
      rm_p_ff    <= rm_p_in;
   end

   // ---------------------------------------------------------------------
   // Outputs: result shown for one cycle in S_DONE
   // ---------------------------------------------------------------------
   always_comb begin
      busy      = state_ff != S_IDLE;
      rsp_valid = state_ff == S_DONE;
      rsp_item.status        = status_ff;
      rsp_item.running_now   = 5'(cur_ff);
      rsp_item.switched      = cur_ff != before_ff;
      rsp_item.created_id    = created_ff;
      rsp_item.queried_state = qstate_ff;
   end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import pts_pkg::*;

   localparam int NUM_THREADS = 32;

   // Scoreboard: mirrors the scheduler tables and checks each rsp transfer
   class sched_scoreboard;
      logic [2:0]  thr_state [NUM_THREADS];
      logic [1:0]  thr_prio  [NUM_THREADS];
      logic [15:0] thr_sleep [NUM_THREADS];
      int          rdyq [3][$];   // index 0 low, 1 normal, 2 high
      int          running;
      int          next_id;
      rsp_type     pending [$];
      int          errors;
      int          events;
      int          switches;

      function void init();
         for (int i = 0; i < NUM_THREADS; i++) begin
            thr_state[i] = TS_EMPTY;
            thr_prio[i]  = PR_IDLE;
            thr_sleep[i] = '0;
         end
         for (int p = 0; p < 3; p++) rdyq[p].delete();
         thr_state[0] = TS_RUNNING;
         thr_prio[0]  = PR_NORMAL;
         thr_state[IDLE_ID] = TS_READY;
         running = 0;
         next_id = 2;
         errors = 0;
         events = 0;
         switches = 0;
      endfunction

      function void push_ready(int t);
         int lvl;
         if (thr_prio[t] != PR_IDLE) begin
            lvl = int'(thr_prio[t]) - 1;
            rdyq[lvl].insert(rdyq[lvl].size(), t);
         end
      endfunction

      function bit any_ready();
         return rdyq[0].size() || rdyq[1].size() || rdyq[2].size();
      endfunction

      function int pop_best();
         if (rdyq[2].size()) return rdyq[2].pop_front();
         if (rdyq[1].size()) return rdyq[1].pop_front();
         return rdyq[0].pop_front();
      endfunction

      function void preempt_by(int lvl);
         int t;
         t = rdyq[lvl].pop_front();
         thr_state[running] = TS_READY;
         push_ready(running);
         running = t;
         thr_state[t] = TS_RUNNING;
      endfunction

      function void reschedule();
         logic [1:0] p;
         bit gone;
         bit rdy;
         p = thr_prio[running];
         gone = thr_state[running] == TS_WAITING || thr_state[running] == TS_DEAD;
         rdy = any_ready();
         if (p == PR_IDLE && !rdy) return;
         if (gone && !rdy) begin
            running = IDLE_ID;
            thr_state[IDLE_ID] = TS_RUNNING;
         end else if (gone) begin
            running = pop_best();
            thr_state[running] = TS_RUNNING;
         end else if (p == PR_IDLE) begin
            thr_state[running] = TS_READY;
            running = pop_best();
            thr_state[running] = TS_RUNNING;
         end else if (p < PR_HIGH && rdyq[2].size()) begin
            preempt_by(2);
         end else if (p < PR_NORMAL && rdyq[1].size()) begin
            preempt_by(1);
         end
      endfunction

      function bit known(int t);
         return thr_state[t] != TS_EMPTY;
      endfunction

      // note an accepted event and queue its expected result
      function void note_event(req_type r);
         rsp_type e;
         int was;
         int tg;
         was = running;
         tg = int'(r.target_thread);
         e = '0;
         e.status = STS_OK;
         case (r.func) inside
            FN_TICK: begin
               for (int i = 0; i < NUM_THREADS; i++) begin
                  if (thr_sleep[i] != 0) begin
                     thr_sleep[i]--;
                     if (thr_sleep[i] == 0) begin
                        thr_state[i] = TS_READY;
                        push_ready(i);
                        reschedule();
                     end
                  end
               end
            end
            FN_CREATE: begin
               if (r.new_priority == PR_IDLE) e.status = STS_BAD_PARAM;
               else if (next_id >= NUM_THREADS) e.status = STS_FULL;
               else begin
                  e.created_id = 5'(next_id);
                  thr_state[next_id] = TS_DEAD;
                  thr_prio[next_id] = r.new_priority;
                  thr_sleep[next_id] = '0;
                  next_id++;
               end
            end
            FN_DELETE, FN_ACTIVATE: begin
               if (!known(tg)) e.status = STS_BAD_ID;
               else if (thr_state[tg] != TS_DEAD) e.status = STS_BAD_STATE;
               else if (r.func == FN_DELETE) begin
                  thr_state[tg] = TS_EMPTY;
                  thr_sleep[tg] = '0;
               end else begin
                  thr_state[tg] = TS_READY;
                  push_ready(tg);
                  reschedule();
               end
            end
            FN_TERMINATE: begin
               if (!known(tg)) e.status = STS_BAD_ID;
               else if (thr_state[tg] == TS_DEAD || tg == IDLE_ID) e.status = STS_BAD_STATE;
               else begin
                  thr_state[tg] = TS_DEAD;
                  thr_sleep[tg] = '0;
                  if (thr_prio[tg] != PR_IDLE) begin
                     int lvl;
                     lvl = int'(thr_prio[tg]) - 1;
                     for (int k = rdyq[lvl].size() - 1; k >= 0; k--)
                        if (rdyq[lvl][k] == tg) rdyq[lvl].delete(k);
                  end
                  reschedule();
               end
            end
            FN_SLEEP: begin
               if (r.sleep_forever) e.status = STS_BAD_PARAM;
               else if (running == IDLE_ID) e.status = STS_BAD_STATE;
               else if (r.sleep_ticks == 0) begin
                  // yield: requeue, then the best ready thread runs
                  thr_state[running] = TS_READY;
                  push_ready(running);
                  running = pop_best();
                  thr_state[running] = TS_RUNNING;
               end else begin
                  thr_state[running] = TS_WAITING;
                  thr_sleep[running] = r.sleep_ticks;
                  reschedule();
               end
            end
            FN_IO_WAIT: begin
               if (running == IDLE_ID) e.status = STS_BAD_STATE;
               else begin
                  thr_state[running] = TS_WAITING;
                  thr_sleep[running] = '0;
                  reschedule();
               end
            end
            FN_IO_DONE: begin
               if (!known(tg)) e.status = STS_BAD_ID;
               else if (thr_state[tg] != TS_WAITING || thr_sleep[tg] != 0)
                  e.status = STS_BAD_STATE;
               else begin
                  thr_state[tg] = TS_READY;
                  push_ready(tg);
                  reschedule();
               end
            end
            FN_QUERY: begin
               if (!known(tg)) begin
                  e.status = STS_BAD_ID;
                  e.queried_state = TS_EMPTY;
               end else e.queried_state = thr_state[tg];
            end
            default: e.status = STS_BAD_PARAM;
         endcase
         e.running_now = 5'(running);
         e.switched = running != was;
         if (e.switched) switches++;
         events++;
         pending.insert(pending.size(), e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
         end
         if (a.running_now !== e.running_now) begin
            $error("running_now: expected %0d, got %0d", e.running_now, a.running_now);
            errors++;
         end
         if (a.switched !== e.switched) begin
            $error("switched: expected %0d, got %0d", e.switched, a.switched);
            errors++;
         end
         if (a.created_id !== e.created_id) begin
            $error("created_id: expected %0d, got %0d", e.created_id, a.created_id);
            errors++;
         end
         if (a.queried_state !== e.queried_state) begin
            $error("queried_state: expected %0d, got %0d", e.queried_state,
                   a.queried_state);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   sched_scoreboard sb;
   bit      gaps_on;

   priority_thread_scheduler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // sample the result port at each rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // drive one event; held until the transfer edge, replaced or released later
   task automatic issue(req_type r);
      while (gaps_on && $urandom_range(99) < 29) begin
         start <= 1'b0;
         req_item <= '0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_event(r);
      @(negedge clock);
   endtask

   task automatic send(logic [3:0] f, int tg = 0, int pr = 0, int tk = 0, bit fv = 0);
      req_type r;
      r.func = f;
      r.target_thread = 5'(tg);
      r.new_priority = 2'(pr);
      r.sleep_ticks = 16'(tk);
      r.sleep_forever = fv;
      issue(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      req_item <= '0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // mostly well-formed events aimed at live threads, some raw noise
   task automatic send_random();
      req_type r;
      int sel;
      r = '0;
      r.sleep_ticks = 16'($urandom_range(9, 1));
      r.target_thread = 5'($urandom_range(sb.next_id - 1));
      r.new_priority = 2'($urandom_range(3, 1));
      sel = $urandom_range(99);
      if (sel < 8) begin
         r = req_type'(28'($urandom));
         r.func = 4'($urandom_range(15));
      end else if (sel < 28) r.func = FN_TICK;
      else if (sel < 34) r.func = FN_CREATE;
      else if (sel < 37) r.func = FN_DELETE;
      else if (sel < 52) r.func = FN_ACTIVATE;
      else if (sel < 60) r.func = FN_TERMINATE;
      else if (sel < 72) begin
         r.func = FN_SLEEP;
         if ($urandom_range(4) == 0) r.sleep_ticks = 0;
         if ($urandom_range(19) == 0) r.sleep_forever = 1'b1;
      end else if (sel < 80) r.func = FN_IO_WAIT;
      else if (sel < 92) r.func = FN_IO_DONE;
      else r.func = FN_QUERY;
      issue(r);
   endtask

   initial begin
      sb = new();
      sb.init();
      gaps_on = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset state, error paths, every event code
      send(FN_QUERY, 0);
      send(FN_QUERY, 1);
      send(FN_QUERY, 31);
      send(FN_CREATE, 0, 0);                 // priority zero rejected
      send(FN_CREATE, 0, 3);                 // id 2 high
      send(FN_CREATE, 0, 1);                 // id 3 low
      send(FN_CREATE, 0, 2);                 // id 4 normal
      send(FN_ACTIVATE, 3);                  // low, no preemption
      send(FN_ACTIVATE, 2);                  // high preempts main
      send(FN_ACTIVATE, 2);                  // not dead
      send(FN_SLEEP, 0, 0, 16'hFFFF, 1);     // forever rejected
      send(FN_SLEEP, 0, 0, 0);               // yield
      send(FN_SLEEP, 0, 0, 16'hFFFF);        // longest sleep
      send(FN_IO_WAIT);
      send(FN_IO_DONE, 2);
      send(FN_IO_DONE, 0);                   // waiting on I/O, woken
      send(FN_TERMINATE, 1);                 // idle cannot be terminated
      send(FN_TERMINATE, 3);
      send(FN_DELETE, 3);
      send(FN_DELETE, 3);                    // now empty
      send(FN_TERMINATE, 0);
      send(FN_TICK);
      send(4'hF, 31, 3, 16'hFFFF, 1);        // unknown code
      send(FN_SLEEP, 0, 0, 5);
      send(FN_IO_WAIT);

      // pause until the block has answered everything
      drain();

      for (int n = 0; n < 750; n++) begin
         gaps_on = !(n >= 200 && n < 350);
         if (n == 500) drain();
         send_random();
      end
      gaps_on = 1'b0;
      // run the table out of ids so the full case is hit
      repeat (32) send(FN_CREATE, 0, $urandom_range(3, 1));

      drain();
      repeat (200) @(negedge clock);
      $display("covered %0d events with %0d thread switches; %0d ids handed out",
               sb.events, sb.switches, sb.next_id);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("priority_thread_scheduler_core test passed");
      else
         $display("priority_thread_scheduler_core test failed");
      $finish;
   end

   // watchdog sized for about 810 events plus gaps, with a wide margin
   initial begin
      #2000000;
      $display("priority_thread_scheduler_core test failed");
      $finish;
   end

endmodule
